// ----- design/olbd_pkg.sv -----
`default_nettype none

package olbd_pkg;

    // Reply limits.
    localparam int MAX_REPLY_BYTES = 128;
    localparam int MAX_DIGITS      = 4;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 16;
    localparam int DIGIT_W = 3;
    localparam int MATCH_W = 4;
    localparam int INTRO_LEN = 9;

    // Character codes.
    localparam logic [BYTE_W-1:0] CHAR_BEL   = 8'h07;
    localparam logic [BYTE_W-1:0] CHAR_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CHAR_BSL   = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;

    // Luminance weights, scaled by one thousand.
    localparam int COEF_W = 32;
    localparam logic [COEF_W-1:0] COEF_R    = 32'd299;
    localparam logic [COEF_W-1:0] COEF_G    = 32'd587;
    localparam logic [COEF_W-1:0] COEF_B    = 32'd114;
    localparam logic [COEF_W-1:0] COEF_FULL = 32'd1000;

    // Multiplier operand and product widths.
    localparam int MUL_A_W = 26;
    localparam int MUL_P_W = MUL_A_W + COEF_W;
    localparam int ACC_W   = 60;

    // Parser result passed to the luminance unit.
    typedef struct packed {
        logic                              done;
        logic                              ok;
        logic [2:0][VALUE_W-1:0]           value;
        logic [2:0][DIGIT_W-1:0]           digits;
    } olbd_reply_t;

    // Verdict offered by the luminance unit.
    typedef struct packed {
        logic valid;
        logic ok;
        logic light;
    } olbd_result_t;

    // Bytes of the introducer ESC ] 1 1 ; r g b :
    function automatic logic [BYTE_W-1:0] prefix_byte(input logic [MATCH_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        begin
            case (idx)
                4'd0:    ch = CHAR_ESC;
                4'd1:    ch = 8'h5D;
                4'd2:    ch = 8'h31;
                4'd3:    ch = 8'h31;
                4'd4:    ch = 8'h3B;
                4'd5:    ch = 8'h72;
                4'd6:    ch = 8'h67;
                4'd7:    ch = 8'h62;
                4'd8:    ch = 8'h3A;
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

    // Hex digit decode: bit 4 marks a valid digit.
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] ch);
        logic [4:0] res;
        begin
            res = 5'd0;
            if (ch >= 8'h30 && ch <= 8'h39)
            begin
                res = {1'b1, 4'(ch - 8'h30)};
            end
            else if (ch >= 8'h61 && ch <= 8'h66)
            begin
                res = {1'b1, 4'(ch - 8'h57)};
            end
            else if (ch >= 8'h41 && ch <= 8'h46)
            begin
                res = {1'b1, 4'(ch - 8'h37)};
            end
            return res;
        end
    endfunction

    // Full-scale value of a component with the given number of digits.
    function automatic logic [VALUE_W-1:0] full_scale(input logic [DIGIT_W-1:0] d);
        logic [VALUE_W-1:0] m;
        begin
            case (d)
                3'd1:    m = 16'h000F;
                3'd2:    m = 16'h00FF;
                3'd3:    m = 16'h0FFF;
                3'd4:    m = 16'hFFFF;
                default: m = 16'h0000;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/olbd_parser.sv -----
`default_nettype none

module olbd_parser
    import olbd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              end_of_reply,
    output olbd_reply_t            reply
);

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_COMP   = 2'd1;
    localparam logic [1:0] PH_OK     = 2'd2;
    localparam logic [1:0] PH_FAIL   = 2'd3;

    logic [MATCH_W-1:0]          match_reg, match_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [1:0]                  idx_reg, idx_next;
    logic [2:0][VALUE_W-1:0]     value_reg, value_next;
    logic [2:0][DIGIT_W-1:0]     digits_reg, digits_next;
    logic                        esc_reg, esc_next;
    logic [BYTE_W-1:0]           seen_reg, seen_next;
    logic                        done;
    logic                        ok;
    logic [4:0]                  hex;

    // Next state for one byte of the reply.
    always_comb
    begin
        match_next  = match_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        value_next  = value_reg;
        digits_next = digits_reg;
        esc_next    = 1'b0;
        done        = 1'b0;
        hex         = hex_decode(rx_byte);

        case (phase_reg)
            PH_SEARCH:
            begin
                if (rx_byte == prefix_byte(match_reg))
                begin
                    match_next = match_reg + 1'b1;
                    if (match_next == MATCH_W'(INTRO_LEN))
                    begin
                        phase_next = PH_COMP;
                        idx_next   = 2'd0;
                    end
                end
                else
                begin
                    match_next = (rx_byte == CHAR_ESC) ? MATCH_W'(1) : MATCH_W'(0);
                end
            end
            PH_COMP:
            begin
                if (hex[4])
                begin
                    if (digits_reg[idx_reg] >= DIGIT_W'(MAX_DIGITS))
                    begin
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        value_next[idx_reg]  = {value_reg[idx_reg][VALUE_W-5:0], hex[3:0]};
                        digits_next[idx_reg] = digits_reg[idx_reg] + 1'b1;
                    end
                end
                else if (digits_reg[idx_reg] == '0)
                begin
                    phase_next = PH_FAIL;
                end
                else if (idx_reg != 2'd2)
                begin
                    if (rx_byte == CHAR_SLASH)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                else
                begin
                    phase_next = PH_OK;
                end
            end
            default:
            begin
            end
        endcase

        // End of reply detection.
        seen_next = seen_reg + 1'b1;
        if (esc_reg)
        begin
            done = (rx_byte == CHAR_BSL);
        end
        else if (rx_byte == CHAR_BEL)
        begin
            done = 1'b1;
        end
        else if (rx_byte == CHAR_ESC)
        begin
            esc_next = 1'b1;
        end
        if (seen_next >= BYTE_W'(MAX_REPLY_BYTES) || end_of_reply)
        begin
            done = 1'b1;
        end

        ok = (phase_next == PH_OK) ||
             (phase_next == PH_COMP && idx_next == 2'd2 && digits_next[2] != '0);
    end

    assign reply.done   = accept & done;
    assign reply.ok     = ok;
    assign reply.value  = value_next;
    assign reply.digits = digits_next;

    // Control state returns to idle once a reply has ended.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg  <= '0;
            phase_reg  <= PH_SEARCH;
            idx_reg    <= '0;
            value_reg  <= '0;
            digits_reg <= '0;
            esc_reg    <= 1'b0;
            seen_reg   <= '0;
        end
        else if (accept)
        begin
            if (done)
            begin
                match_reg  <= '0;
                phase_reg  <= PH_SEARCH;
                idx_reg    <= '0;
                value_reg  <= '0;
                digits_reg <= '0;
                esc_reg    <= 1'b0;
                seen_reg   <= '0;
            end
            else
            begin
                match_reg  <= match_next;
                phase_reg  <= phase_next;
                idx_reg    <= idx_next;
                value_reg  <= value_next;
                digits_reg <= digits_next;
                esc_reg    <= esc_next;
                seen_reg   <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/olbd_luma.sv -----
`default_nettype none

module olbd_luma
    import olbd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire olbd_reply_t  reply,
    input  wire logic         take,
    output logic              busy,
    output olbd_result_t      result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    // Sequencer steps; the product of one step is stored in the next.
    localparam logic [3:0] STEP_MGB   = 4'd0;
    localparam logic [3:0] STEP_MRB   = 4'd1;
    localparam logic [3:0] STEP_MRG   = 4'd2;
    localparam logic [3:0] STEP_KR    = 4'd3;
    localparam logic [3:0] STEP_KG    = 4'd4;
    localparam logic [3:0] STEP_KB    = 4'd5;
    localparam logic [3:0] STEP_KF    = 4'd6;
    localparam logic [3:0] STEP_SUMR  = 4'd7;
    localparam logic [3:0] STEP_SUMG  = 4'd8;
    localparam logic [3:0] STEP_SUMB  = 4'd9;
    localparam logic [3:0] STEP_FULL  = 4'd10;
    localparam logic [3:0] STEP_CMP   = 4'd11;

    logic [1:0]             state_reg;
    logic [3:0]             step_reg;
    logic                   ok_reg;
    logic                   light_reg;
    logic [VALUE_W-1:0]     r_reg, g_reg, b_reg;
    logic [VALUE_W-1:0]     mr_reg, mg_reg, mb_reg;
    logic [COEF_W-1:0]      t1_reg, t2_reg, t3_reg;
    logic [MUL_A_W-1:0]     kr_reg, kg_reg, kb_reg, kf_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [MUL_P_W-1:0]     prod_reg;
    logic [MUL_A_W-1:0]     mul_a;
    logic [COEF_W-1:0]      mul_b;
    logic [MUL_P_W-1:0]     prod_next;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (step_reg)
            STEP_MGB:  begin mul_a = MUL_A_W'(mg_reg); mul_b = COEF_W'(mb_reg); end
            STEP_MRB:  begin mul_a = MUL_A_W'(mr_reg); mul_b = COEF_W'(mb_reg); end
            STEP_MRG:  begin mul_a = MUL_A_W'(mr_reg); mul_b = COEF_W'(mg_reg); end
            STEP_KR:   begin mul_a = MUL_A_W'(r_reg);  mul_b = COEF_R;          end
            STEP_KG:   begin mul_a = MUL_A_W'(g_reg);  mul_b = COEF_G;          end
            STEP_KB:   begin mul_a = MUL_A_W'(b_reg);  mul_b = COEF_B;          end
            STEP_KF:   begin mul_a = MUL_A_W'(mr_reg); mul_b = COEF_FULL;       end
            STEP_SUMR: begin mul_a = kr_reg;           mul_b = t1_reg;          end
            STEP_SUMG: begin mul_a = kg_reg;           mul_b = t2_reg;          end
            STEP_SUMB: begin mul_a = kb_reg;           mul_b = t3_reg;          end
            STEP_FULL: begin mul_a = kf_reg;           mul_b = t1_reg;          end
            default:   begin mul_a = '0;               mul_b = '0;              end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Sequencer and result hold.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ok_reg    <= 1'b0;
            light_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (reply.done)
                    begin
                        ok_reg    <= reply.ok;
                        light_reg <= 1'b0;
                        step_reg  <= STEP_MGB;
                        state_reg <= reply.ok ? ST_CALC : ST_HOLD;
                    end
                end
                ST_CALC:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_CMP)
                    begin
                        light_reg <= {acc_reg, 1'b0} >= (ACC_W + 1)'(prod_reg);
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Operand capture, product register and partial results.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && reply.done)
        begin
            r_reg  <= reply.value[0];
            g_reg  <= reply.value[1];
            b_reg  <= reply.value[2];
            mr_reg <= full_scale(reply.digits[0]);
            mg_reg <= full_scale(reply.digits[1]);
            mb_reg <= full_scale(reply.digits[2]);
        end
        prod_reg <= prod_next;
        if (state_reg == ST_CALC)
        begin
            case (step_reg)
                STEP_MRB:  t1_reg  <= COEF_W'(prod_reg);
                STEP_MRG:  t2_reg  <= COEF_W'(prod_reg);
                STEP_KR:   t3_reg  <= COEF_W'(prod_reg);
                STEP_KG:   kr_reg  <= MUL_A_W'(prod_reg);
                STEP_KB:   kg_reg  <= MUL_A_W'(prod_reg);
                STEP_KF:   kb_reg  <= MUL_A_W'(prod_reg);
                STEP_SUMR: kf_reg  <= MUL_A_W'(prod_reg);
                STEP_SUMG: acc_reg <= ACC_W'(prod_reg);
                STEP_SUMB: acc_reg <= acc_reg + ACC_W'(prod_reg);
                STEP_FULL: acc_reg <= acc_reg + ACC_W'(prod_reg);
                default:
                begin
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result.valid = (state_reg == ST_HOLD);
    assign result.ok    = ok_reg;
    assign result.light = light_reg;

endmodule

`default_nettype wire

// ----- design/osc11_reply_light_background_detect.sv -----
// Terminal background colour reply detector.
// The input channel (in_valid, in_ready, rx_byte, end_of_reply) takes one reply
// byte per transfer. A reply ends on BEL, on ESC followed by a backslash, when
// the byte limit is reached, or on a byte sent with end_of_reply set.
// For each reply the output channel (out_valid, out_ready, parse_ok, bg_light)
// gives one verdict: whether an rgb background reply was parsed and whether its
// luminance is at least one half.
// Bytes that do not end a reply may follow back to back while the luminance unit is idle.
// A reply-ending byte starts the luminance test on a single shared multiplier:
// eleven products and a final compare; out_valid rises once the verdict has
// moved into the output register, and in_ready stays low from the transfer of
// the ending byte until then. A malformed reply skips the arithmetic.
// If the receiver stalls, the verdict waits in the output register; a following
// verdict then waits in the luminance unit and input transfers pause.
// Reset clears the parser, the sequencer and the output valid flag.
`default_nettype none

module osc11_reply_light_background_detect
    import olbd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              end_of_reply,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   parse_ok,
    output logic                   bg_light
);

    olbd_reply_t  reply;
    olbd_result_t result;
    logic         luma_busy;
    logic         take;
    logic         out_valid_reg;
    logic         parse_ok_reg;
    logic         bg_light_reg;

    assign in_ready = !luma_busy;
    assign take     = result.valid && (!out_valid_reg || out_ready);

    olbd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_valid && in_ready),
        .rx_byte      (rx_byte),
        .end_of_reply (end_of_reply),
        .reply        (reply)
    );

    olbd_luma u_luma (
        .clk    (clk),
        .rst_n  (rst_n),
        .reply  (reply),
        .take   (take),
        .busy   (luma_busy),
        .result (result)
    );

    // Output register: holds the verdict until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            parse_ok_reg <= result.ok;
            bg_light_reg <= result.ok & result.light;
        end
    end

    assign out_valid = out_valid_reg;
    assign parse_ok  = parse_ok_reg;
    assign bg_light  = bg_light_reg;

endmodule

`default_nettype wire

// ----- design/olbd_checker.sv -----
`default_nettype none

module olbd_checker
    import olbd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              end_of_reply,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              parse_ok,
    input wire logic              bg_light
);

    // A stalled verdict holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(parse_ok) && $stable(bg_light))
        else $error("verdict changed while stalled");

    // A failed parse never reports a light background.
    a_fail_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !parse_ok |-> !bg_light)
        else $error("light verdict on a failed parse");

    // A transfer that ends a reply makes the input wait for its verdict.
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_reply |=> !in_ready)
        else $error("input still ready after a reply ended");

    // A new verdict only appears while the input is paused.
    a_verdict_paused: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("verdict appeared without a finished reply");

endmodule

bind osc11_reply_light_background_detect olbd_checker u_olbd_checker (.*);

`default_nettype wire

// ----- dv/osc11_reply_light_background_detect_tb.sv -----
module osc11_reply_light_background_detect_tb;
    import olbd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_BYTES = 1100;
    localparam int STEADY_AFTER = 900;

    // The introducer ESC ] 1 1 ; r g b : with its first byte in the top octet.
    localparam logic [8*INTRO_LEN-1:0] INTRO_BYTES = {CHAR_ESC, "]11;rgb:"};

    typedef logic [BYTE_W-1:0] octets_t[$];

    typedef struct packed {
        logic ok;
        logic light;
    } verdict_t;

    typedef enum logic [2:0] {
        SCAN_PREFIX,
        READ_COMPONENTS,
        REPLY_GOOD,
        REPLY_BAD
    } parse_phase_e;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              end_of_reply;
    logic              out_valid;
    logic              out_ready;
    logic              parse_ok;
    logic              bg_light;

    // Parser state tracked alongside the block.
    parse_phase_e       phase;
    logic [MATCH_W-1:0] intro_matched;
    logic [1:0]         comp_sel;
    logic [VALUE_W-1:0] comp_val[3];
    logic [DIGIT_W-1:0] comp_digits[3];
    logic               esc_pending;
    logic [BYTE_W-1:0]  reply_len;

    verdict_t expected_verdicts[$];
    verdict_t head_verdict;
    int       errors = 0;
    int       cycles = 0;
    int       bytes_sent = 0;
    int       hold_left = 0;
    bit       quiet = 1'b0;
    bit       steady = 1'b0;

    osc11_reply_light_background_detect dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .end_of_reply (end_of_reply),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parse_ok     (parse_ok),
        .bg_light     (bg_light)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void clear_tracker();
        phase         = SCAN_PREFIX;
        intro_matched = '0;
        comp_sel      = '0;
        esc_pending   = 1'b0;
        reply_len     = '0;
        for (int k = 0; k < 3; k++)
        begin
            comp_val[k]    = '0;
            comp_digits[k] = '0;
        end
    endfunction

    function automatic int hex_nibble(input logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    // Exact BT.601 test: each component is scaled by the full scale of its digit count.
    function automatic logic light_enough();
        logic [63:0] mr, mg, mb, r, g, b, lhs, rhs;
        mr  = (64'd1 << (4 * comp_digits[0])) - 64'd1;
        mg  = (64'd1 << (4 * comp_digits[1])) - 64'd1;
        mb  = (64'd1 << (4 * comp_digits[2])) - 64'd1;
        r   = 64'(comp_val[0]);
        g   = 64'(comp_val[1]);
        b   = 64'(comp_val[2]);
        lhs = 64'd2 * (64'(COEF_R) * r * mg * mb + 64'(COEF_G) * g * mr * mb
                       + 64'(COEF_B) * b * mr * mg);
        rhs = 64'(COEF_FULL) * mr * mg * mb;
        return lhs >= rhs;
    endfunction

    // Advance the tracked parser by one byte and say whether the reply ends here.
    task automatic track_byte(input logic [BYTE_W-1:0] c, input logic eor,
                              output logic finished, output verdict_t v);
        int          nib;
        int          idx;
        logic [BYTE_W-1:0] want;
        nib = hex_nibble(c);
        idx = int'(comp_sel) % 3;
        if (phase == SCAN_PREFIX)
        begin
            want = INTRO_BYTES[8 * (INTRO_LEN - 1 - int'(intro_matched)) +: 8];
            if (c == want)
            begin
                intro_matched = intro_matched + 1'b1;
                if (int'(intro_matched) >= INTRO_LEN)
                begin
                    phase    = READ_COMPONENTS;
                    comp_sel = '0;
                end
            end
            else
            begin
                intro_matched = (c == CHAR_ESC) ? MATCH_W'(1) : '0;
            end
        end
        else if (phase == READ_COMPONENTS)
        begin
            if (nib >= 0)
            begin
                if (int'(comp_digits[idx]) >= MAX_DIGITS)
                    phase = REPLY_BAD;
                else
                begin
                    comp_val[idx]    = (comp_val[idx] << 4) | VALUE_W'(nib);
                    comp_digits[idx] = comp_digits[idx] + 1'b1;
                end
            end
            else if (comp_digits[idx] == '0)
                phase = REPLY_BAD;
            else if (idx < 2)
            begin
                if (c == CHAR_SLASH)
                    comp_sel = 2'(idx + 1);
                else
                    phase = REPLY_BAD;
            end
            else
                phase = REPLY_GOOD;
        end

        // Reply end detection; the byte after an escape is only checked for a backslash.
        reply_len = reply_len + 1'b1;
        finished  = 1'b0;
        if (esc_pending)
        begin
            esc_pending = 1'b0;
            if (c == CHAR_BSL)
                finished = 1'b1;
        end
        else if (c == CHAR_BEL)
            finished = 1'b1;
        else if (c == CHAR_ESC)
            esc_pending = 1'b1;
        if (int'(reply_len) >= MAX_REPLY_BYTES || eor)
            finished = 1'b1;

        v.ok    = (phase == REPLY_GOOD) ||
                  (phase == READ_COMPONENTS && comp_sel == 2'd2 && comp_digits[2] != '0);
        v.light = v.ok && light_enough();
        if (finished)
            clear_tracker();
    endtask

    // Offer one byte, wait for its transfer and record any verdict it causes.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eor);
        logic     finished;
        verdict_t v;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        rx_byte      <= b;
        end_of_reply <= eor;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_byte(b, eor, finished, v);
        if (finished)
            expected_verdicts.push_back(v);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_reply(input octets_t q, input logic eor_last);
        quiet = steady || ($urandom_range(0, 3) == 0);
        for (int k = 0; k < q.size(); k++)
        begin
            send_byte(q[k], eor_last && (k == q.size() - 1));
        end
    endtask

    function automatic octets_t text_octets(input string s);
        octets_t q;
        for (int k = 0; k < s.len(); k++)
        begin
            q.push_back(s[k]);
        end
        return q;
    endfunction

    // Introducer followed by the given body.
    function automatic octets_t osc_reply(input string body);
        octets_t q;
        q = text_octets({"]11;rgb:", body});
        q.push_front(CHAR_ESC);
        return q;
    endfunction

    function automatic octets_t with_bel(input octets_t q);
        octets_t r;
        r = q;
        r.push_back(CHAR_BEL);
        return r;
    endfunction

    function automatic octets_t with_st(input octets_t q);
        octets_t r;
        r = q;
        r.push_back(CHAR_ESC);
        r.push_back(CHAR_BSL);
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input int v);
        if (v < 10)
            return "0" + BYTE_W'(v);
        if ($urandom_range(0, 1) == 0)
            return "a" + BYTE_W'(v - 10);
        return "A" + BYTE_W'(v - 10);
    endfunction

    // Compare each verdict transfer with the oldest one outstanding.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
                report_error("verdict transfer with none outstanding");
            else
            begin
                head_verdict = expected_verdicts.pop_front();
                if (parse_ok !== head_verdict.ok)
                    report_error($sformatf("parse_ok mismatch, expected %0b, got %0b",
                                           head_verdict.ok, parse_ok));
                if (bg_light !== head_verdict.light)
                    report_error($sformatf("bg_light mismatch, expected %0b, got %0b",
                                           head_verdict.light, bg_light));
            end
        end
    end

    // Receiver back-pressure in short bursts, none in quiet stretches.
    always @(negedge clk)
    begin
        if (quiet)
            out_ready <= 1'b1;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            hold_left = $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    // Darkest and brightest colours, single digits, mixed digit counts.
    task automatic test_colour_extremes();
        send_reply(with_bel(osc_reply("0/0/0")), 1'b0);
        send_reply(with_st(osc_reply("ffff/FFFF/ffff")), 1'b0);
        send_reply(osc_reply("f/0/0"), 1'b1);
        send_reply(with_bel(osc_reply("0/F/0")), 1'b0);
        send_reply(with_bel(osc_reply("80/80/80")), 1'b0);
        send_reply(with_st(osc_reply("7fff/7fff/7fff")), 1'b0);
        send_reply(with_bel(osc_reply("A/bC/dEf9")), 1'b0);
        send_reply(with_bel(osc_reply("1/22/333")), 1'b0);
    endtask

    // Replies ended by BEL or by end_of_reply, and escapes that must not end them.
    task automatic test_reply_endings();
        octets_t q;
        // A BEL straight after an escape does not end the reply.
        q = osc_reply("ff/ff/ff");
        q.push_back(CHAR_ESC);
        q.push_back(CHAR_BEL);
        send_reply(with_bel(q), 1'b0);
        // An escape straight after an escape does not arm a new one.
        q = osc_reply("0/0/0");
        q.push_back(CHAR_ESC);
        q.push_back(CHAR_ESC);
        q.push_back(CHAR_BSL);
        send_reply(with_bel(q), 1'b0);
        // Source ends part way through the introducer.
        q = {CHAR_ESC};
        q = {q, text_octets("]1")};
        send_reply(q, 1'b1);
        // An empty reply.
        q = {CHAR_BEL};
        send_reply(q, 1'b0);
    endtask

    // Introducer matching restarts on a mismatch, at one if the byte is an escape.
    task automatic test_prefix_restart();
        octets_t q;
        q = {CHAR_ESC};
        q = {q, text_octets("]1"), osc_reply("ffff/ffff/ffff")};
        send_reply(with_bel(q), 1'b0);
        q = {text_octets("zz]11;rgb:f/f/f"), osc_reply("0/0/0")};
        send_reply(with_bel(q), 1'b0);
        // A second introducer after the blue component is ignored.
        q = {osc_reply("1/2/3"), osc_reply("f/f/f")};
        send_reply(with_bel(q), 1'b0);
    endtask

    task automatic test_malformed_replies();
        send_reply(with_bel(osc_reply("12345/0/0")), 1'b0);
        send_reply(with_bel(osc_reply("0/0/fffff")), 1'b0);
        send_reply(with_bel(osc_reply("/1/1")), 1'b0);
        send_reply(with_bel(osc_reply("1:2/3")), 1'b0);
        send_reply(with_bel(osc_reply("1/2/")), 1'b0);
        send_reply(with_bel(osc_reply("1/2")), 1'b0);
        send_reply(osc_reply("1/2/3zzz"), 1'b1);
    endtask

    // Replies cut off by the byte limit.
    task automatic test_byte_limit();
        octets_t q;
        q = {};
        repeat (MAX_REPLY_BYTES) q.push_back("x");
        send_reply(q, 1'b0);
        q = osc_reply("ffff/ffff/ffff");
        while (q.size() < MAX_REPLY_BYTES)
            q.push_back("y");
        send_reply(q, 1'b0);
    endtask

    // Mostly well-formed replies with random content, the rest broken or noise.
    task automatic test_random_replies();
        octets_t q;
        int      ndig;
        int      start;
        logic    eor_last;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            steady   = (bytes_sent - start) >= STEADY_AFTER;
            q        = {};
            eor_last = 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) q.push_back(BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) < 8)
            begin
                q = {q, osc_reply("")};
                if ($urandom_range(0, 19) == 0)
                    q[$urandom_range(0, q.size() - 1)] = BYTE_W'($urandom_range(0, 255));
                for (int k = 0; k < 3; k++)
                begin
                    ndig = $urandom_range(1, MAX_DIGITS);
                    if ($urandom_range(0, 24) == 0)
                        ndig = ($urandom_range(0, 1) == 0) ? 0 : MAX_DIGITS + 1;
                    repeat (ndig) q.push_back(hex_char($urandom_range(0, 15)));
                    if (k < 2)
                    begin
                        if ($urandom_range(0, 24) == 0)
                            q.push_back(BYTE_W'($urandom_range(0, 255)));
                        else
                            q.push_back(CHAR_SLASH);
                    end
                end
                case ($urandom_range(0, 4))
                    0: q.push_back(CHAR_BEL);
                    1: q = with_st(q);
                    2: eor_last = 1'b1;
                    3:
                    begin
                        repeat ($urandom_range(1, 6))
                            q.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
                        q.push_back(CHAR_BEL);
                    end
                    default:
                    begin
                        q.push_back(CHAR_ESC);
                        q.push_back(BYTE_W'($urandom_range(0, 255)));
                        eor_last = 1'b1;
                    end
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 40)) q.push_back(BYTE_W'($urandom_range(0, 255)));
                eor_last = 1'($urandom_range(0, 1));
            end
            send_reply(q, eor_last);
        end
    endtask

    // Stimulus sequence and final verdict.
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rx_byte      = '0;
        end_of_reply = 1'b0;
        out_ready    = 1'b0;
        clear_tracker();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_colour_extremes();
        test_reply_endings();
        test_prefix_restart();
        test_malformed_replies();
        test_byte_limit();
        test_random_replies();

        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
